// ===== sv/bac_pkg.sv =====
// ----------------------------------------------------------------------------
// bac_pkg
// Shared types and constants of the background alpha compositor.
// ----------------------------------------------------------------------------
package bac_pkg;

    localparam int BYTE_W        = 8;
    localparam int NUM_LANES     = 8;
    localparam int PIX_W         = BYTE_W * NUM_LANES;
    localparam int MODE_W        = 3;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 64;
    localparam int SPOT_CHANNELS = 4;
    localparam int DEVN_LANES    = (SPOT_CHANNELS + 4 > NUM_LANES) ?
                                   NUM_LANES : SPOT_CHANNELS + 4;

    localparam logic [BYTE_W-1:0] FULL_ALPHA = 8'hff;
    localparam int XBGR_FILL_LANE = 3;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_MODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND = 1'b1;

    localparam logic [MODE_W-1:0] COLOR_MODE_RESET = 3'd2;

    typedef enum logic [MODE_W-1:0] {
        MODE_MONO1 = 3'd0,
        MODE_MONO8 = 3'd1,
        MODE_RGB   = 3'd2,
        MODE_XBGR  = 3'd3,
        MODE_CMYK  = 3'd4,
        MODE_DEVN  = 3'd5
    } t_mode;

    // Per-pixel control that travels down the pipeline with the data.
    typedef struct packed {
        logic                 mono1;
        logic                 xbgr;
        logic [NUM_LANES-1:0] mask;
    } t_ctl;

    // Mask with the lowest n lanes set.
    function automatic logic [NUM_LANES-1:0] low_lanes(input int n);
        logic [NUM_LANES-1:0] m;
        m = '0;
        for (int i = 0; i < NUM_LANES; i++) begin
            if (i < n) begin
                m[i] = 1'b1;
            end
        end
        return m;
    endfunction

endpackage

// ===== sv/bac_in_if.sv =====
// ----------------------------------------------------------------------------
// bac_in_if
// Input pixel channel: coverage and packed channel bytes.
// ----------------------------------------------------------------------------
interface bac_in_if
    import bac_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] coverage;
    logic [PIX_W-1:0]  pixel_in;

    modport source (output valid, output coverage, output pixel_in, input ready);
    modport sink   (input valid, input coverage, input pixel_in, output ready);
endinterface

// ===== sv/bac_out_if.sv =====
// ----------------------------------------------------------------------------
// bac_out_if
// Output pixel channel: packed blended channel bytes.
// ----------------------------------------------------------------------------
interface bac_out_if
    import bac_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_out;

    modport source (output valid, output pixel_out, input ready);
    modport sink   (input valid, input pixel_out, output ready);
endinterface

// ===== sv/background_alpha_composite.sv =====
// ----------------------------------------------------------------------------
// background_alpha_composite
// Blends each pixel over a fixed background color by its 8-bit coverage.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels arrive on i_pix (coverage and up to eight packed channel bytes)
//   and leave on o_pix; a transfer happens when valid and ready are both
//   high. Each active channel byte becomes the rounded value of
//   ((255 - coverage) * bg + coverage * pix) / 255; other bytes pass through.
//   color_mode and background_color are written through i_cfg_we, i_cfg_idx
//   and i_cfg_data. The user must write them only while no pixel is in flight;
//   the block itself does not enforce it.
//   The pipeline has four register stages: mode decode and operand select,
//   the two 8x8 multiplies of every lane, the sum with the divide by 255,
//   and the output register where mono1 and xbgr fix-ups are applied. A
//   result passes these stages in order and is valid on o_pix from the
//   output register; one pixel is taken in every cycle for as long as o_pix
//   is ready.
//
//   All stages advance together. While the output register holds a result
//   that is not taken, the whole pipeline holds and i_pix.ready is low, so
//   nothing is lost or repeated; bubbles ahead of the stalled result do not
//   shrink. Reset clears the stage valid bits and sets color_mode to RGB
//   and the background to black.
// ----------------------------------------------------------------------------
module background_alpha_composite
    import bac_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    bac_in_if.sink                i_pix,
    bac_out_if.source             o_pix,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Configuration registers.
    logic [MODE_W-1:0] r_color_mode;
    logic [PIX_W-1:0]  r_background;

    // Global advance: every stage moves when the output slot is free or
    // being emptied in this cycle.
    logic adv;

    // Stage 1: decoded control and lane operands.
    logic              r_s1_v;
    t_ctl              r_s1_ctl;
    t_ctl              n_s1_ctl;
    logic [BYTE_W-1:0] r_s1_alpha;
    logic [PIX_W-1:0]  r_s1_pix;
    logic [PIX_W-1:0]  r_s1_op;
    logic [PIX_W-1:0]  n_s1_op;
    logic [PIX_W-1:0]  r_s1_bg;

    // Stages 2 and 3: control and original pixel ride along with the lanes.
    logic              r_s2_v;
    t_ctl              r_s2_ctl;
    logic [PIX_W-1:0]  r_s2_pix;
    logic              r_s3_v;
    t_ctl              r_s3_ctl;
    logic [PIX_W-1:0]  r_s3_pix;

    // Stage 4: output register.
    logic              r_out_v;
    logic [PIX_W-1:0]  r_out_pix;
    logic [PIX_W-1:0]  n_out_pix;

    logic [PIX_W-1:0]  lane_res;

    assign adv         = !r_out_v || o_pix.ready;
    assign i_pix.ready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color_mode <= COLOR_MODE_RESET;
            r_background <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_COLOR_MODE: r_color_mode <= i_cfg_data[MODE_W-1:0];
                CFG_BACKGROUND: r_background <= i_cfg_data[PIX_W-1:0];
                default: ;
            endcase
        end
    end

    // Mode decode. Unused mode codes blend nothing, so the pixel passes.
    always_comb begin
        n_s1_ctl = '0;
        n_s1_op  = i_pix.pixel_in;
        unique case (r_color_mode)
            MODE_MONO1: begin
                // The single bit is widened to a full byte before blending.
                n_s1_ctl.mono1       = 1'b1;
                n_s1_ctl.mask        = low_lanes(1);
                n_s1_op[BYTE_W-1:0]  = {BYTE_W{i_pix.pixel_in[0]}};
            end
            MODE_MONO8: n_s1_ctl.mask = low_lanes(1);
            MODE_RGB:   n_s1_ctl.mask = low_lanes(3);
            MODE_XBGR: begin
                n_s1_ctl.mask = low_lanes(3);
                n_s1_ctl.xbgr = 1'b1;
            end
            MODE_CMYK:  n_s1_ctl.mask = low_lanes(4);
            MODE_DEVN:  n_s1_ctl.mask = low_lanes(DEVN_LANES);
            default:    n_s1_ctl.mask = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_s3_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else if (adv) begin
            r_s1_v  <= i_pix.valid;
            r_s2_v  <= r_s1_v;
            r_s3_v  <= r_s2_v;
            r_out_v <= r_s3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_ctl   <= n_s1_ctl;
            r_s1_alpha <= i_pix.coverage;
            r_s1_pix   <= i_pix.pixel_in;
            r_s1_op    <= n_s1_op;
            r_s1_bg    <= r_background;
            r_s2_ctl   <= r_s1_ctl;
            r_s2_pix   <= r_s1_pix;
            r_s3_ctl   <= r_s2_ctl;
            r_s3_pix   <= r_s2_pix;
            r_out_pix  <= n_out_pix;
        end
    end

    // Eight identical byte lanes; each holds stages 2 and 3 internally.
    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        bac_lane u_lane (
            .i_clk   (i_clk),
            .i_en    (adv),
            .i_alpha (r_s1_alpha),
            .i_bg    (r_s1_bg[g*BYTE_W +: BYTE_W]),
            .i_pix   (r_s1_op[g*BYTE_W +: BYTE_W]),
            .o_res   (lane_res[g*BYTE_W +: BYTE_W])
        );
    end

    // Output assembly: blended bytes where the mask says so, original bytes
    // elsewhere, then the alpha byte fill for xbgr and the single result bit
    // for mono1 (the top bit of the blended byte).
    always_comb begin
        n_out_pix = r_s3_pix;
        for (int i = 0; i < NUM_LANES; i++) begin
            if (r_s3_ctl.mask[i]) begin
                n_out_pix[i*BYTE_W +: BYTE_W] = lane_res[i*BYTE_W +: BYTE_W];
            end
        end
        if (r_s3_ctl.xbgr) begin
            n_out_pix[XBGR_FILL_LANE*BYTE_W +: BYTE_W] = FULL_ALPHA;
        end
        if (r_s3_ctl.mono1) begin
            n_out_pix = {r_s3_pix[PIX_W-1:1], lane_res[BYTE_W-1]};
        end
    end

    assign o_pix.valid     = r_out_v;
    assign o_pix.pixel_out = r_out_pix;

endmodule

// ===== sv/bac_lane.sv =====
// ----------------------------------------------------------------------------
// bac_lane
// One channel byte blend: multiply stage, then sum and divide-by-255 stage.
// ----------------------------------------------------------------------------
module bac_lane
    import bac_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [BYTE_W-1:0] i_alpha,
    input  logic [BYTE_W-1:0] i_bg,
    input  logic [BYTE_W-1:0] i_pix,
    output logic [BYTE_W-1:0] o_res
);

    localparam int PROD_W = 2 * BYTE_W;
    localparam int SUM_W  = PROD_W + 1;

    logic [PROD_W-1:0] r_prod_bg;
    logic [PROD_W-1:0] r_prod_pix;
    logic [BYTE_W-1:0] r_res;
    logic [BYTE_W-1:0] n_res;
    logic [SUM_W-1:0]  sum;
    logic [SUM_W-1:0]  rounded;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod_bg  <= PROD_W'(FULL_ALPHA - i_alpha) * PROD_W'(i_bg);
            r_prod_pix <= PROD_W'(i_alpha) * PROD_W'(i_pix);
            r_res      <= n_res;
        end
    end

    // Rounded division by 255 of a sum that never exceeds 255 * 255.
    always_comb begin
        sum     = {1'b0, r_prod_bg} + {1'b0, r_prod_pix};
        rounded = sum + (sum >> BYTE_W) + SUM_W'(9'h080);
        n_res   = rounded[BYTE_W +: BYTE_W];
    end

    assign o_res = r_res;

endmodule

// ===== sv/bac_checker.sv =====
// ----------------------------------------------------------------------------
// bac_checker
// Port-level checks of the compositor's handshake and pipeline timing.
// ----------------------------------------------------------------------------
module bac_checker
    import bac_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             i_in_ready,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic [PIX_W-1:0] i_out_pixel
);

    // The pipeline is empty right after a reset cycle.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

    // Input is taken exactly when the output slot is free or draining.
    a_ready_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_ready == (!i_out_valid || i_out_ready))
        else $error("input ready does not follow output slot");

    // Without stalls, an accepted pixel shows up on the output.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) ##1 i_out_ready ##1 i_out_ready ##1 i_out_ready
        |=> i_out_valid)
        else $error("pixel did not arrive after four cycles");

    // A stalled result holds its valid and its data.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_pixel)))
        else $error("stalled result changed");

endmodule

bind background_alpha_composite bac_checker u_bac_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pix.valid),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_pix.valid),
    .i_out_ready (o_pix.ready),
    .i_out_pixel (o_pix.pixel_out)
);
